[sv/isr64_pkg.sv]
// Shared constants for the 64-bit integer square root unit.
package isr64_pkg;

    localparam int RAD_W              = 64;
    localparam int ROOT_W             = 32;
    localparam int DEF_RADICAND_WIDTH = 64;

endpackage

[sv/integer_square_root_64_unit.sv]
// Top level of the pipelined 64-bit integer square root unit.
//
// Usage:
//   Drive radicand and raise start for one cycle per request. A request is
//   taken at every rising edge where start is high and busy is low; busy
//   stays low, so a new request may enter every cycle.
//   Each request produces one result: root holds floor(sqrt(radicand)) for
//   exactly one cycle while done is high. Results come out in request order.
//   Structure: one registered pipeline stage per root digit (one compare and
//   subtract per stage).
//   Throughput: one request per cycle.
//   Radicand bits at or above RADICAND_WIDTH are ignored.
//   The receiver cannot stall: done is a strobe and root must be taken in
//   that cycle.
//   Reset clears every stage valid bit; requests in flight are dropped and
//   done stays low until new requests have passed through.
module integer_square_root_64_unit #(
    parameter int RADICAND_WIDTH = isr64_pkg::DEF_RADICAND_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [isr64_pkg::RAD_W-1:0]    radicand,
    output logic                           done,
    output logic [isr64_pkg::ROOT_W-1:0]   root
);

    import isr64_pkg::*;

    localparam int STEPS    = (RADICAND_WIDTH + 1) / 2;
    localparam int REM_W    = STEPS + 2;
    localparam int RAD_BITS = 2 * STEPS;

    logic                accept;
    logic [RAD_BITS-1:0] rad_masked;

    logic                valid_chain [STEPS+1];
    logic [REM_W-1:0]    rem_chain   [STEPS+1];
    logic [STEPS-1:0]    root_chain  [STEPS+1];
    logic [RAD_BITS-1:0] rad_chain   [STEPS+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // drop radicand bits at or above the configured width
    assign rad_masked = radicand[RAD_BITS-1:0]
                      & ({RAD_BITS{1'b1}} >> (RAD_BITS - RADICAND_WIDTH));

    assign valid_chain[0] = accept;
    assign rem_chain[0]   = '0;
    assign root_chain[0]  = '0;
    assign rad_chain[0]   = rad_masked;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_stage
        isr64_stage #(
            .STEPS (STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[g]),
            .rem_in    (rem_chain[g]),
            .root_in   (root_chain[g]),
            .rad_in    (rad_chain[g]),
            .valid_out (valid_chain[g+1]),
            .rem_out   (rem_chain[g+1]),
            .root_out  (root_chain[g+1]),
            .rad_out   (rad_chain[g+1])
        );
    end

    assign done = valid_chain[STEPS];
    assign root = ROOT_W'(root_chain[STEPS]);

`ifndef SYNTH
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a pipeline that never stalls");

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((64'(root) * 64'(root)) <= 64'($past(rad_masked, STEPS))))
        else $error("root squared exceeds the radicand");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (((65'(root) + 65'd1) * (65'(root) + 65'd1))
                  > 130'($past(rad_masked, STEPS))))
        else $error("root plus one squared does not exceed the radicand");
`endif

endmodule

[sv/isr64_stage.sv]
// One registered digit step of the restoring square root pipeline.
module isr64_stage #(
    parameter int STEPS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic [STEPS+1:0]     rem_in,
    input  logic [STEPS-1:0]     root_in,
    input  logic [2*STEPS-1:0]   rad_in,
    output logic                 valid_out,
    output logic [STEPS+1:0]     rem_out,
    output logic [STEPS-1:0]     root_out,
    output logic [2*STEPS-1:0]   rad_out
);

    localparam int REM_W = STEPS + 2;
    localparam int RAD_BITS = 2 * STEPS;

    logic                valid_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [STEPS-1:0]    root_reg;
    logic [STEPS-1:0]    root_next;
    logic [RAD_BITS-1:0] rad_reg;
    logic [RAD_BITS-1:0] rad_next;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                ge;

    always_comb
    begin
        // bring down the next radicand pair; the top two remainder bits are always zero
        rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_BITS-1 -: 2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = (root_in << 1) | STEPS'(ge);
        rad_next  = rad_in << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign rad_out   = rad_reg;

`ifndef SYNTH
    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(valid_in))
        else $error("stage valid without a request one cycle earlier");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (rem_in <= REM_W'({root_in, 1'b0})) |=>
            (rem_reg <= REM_W'({root_reg, 1'b0})))
        else $error("stage remainder exceeds twice the partial root");

    a_rem_fits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (rem_reg <= REM_W'({root_reg, 1'b0})) |->
            (rem_reg[REM_W-1 -: 2] == 2'b00 || root_reg[STEPS-1]))
        else $error("stage remainder spills into the dropped bits");
`endif

endmodule

[verif/isr64_root_scoreboard_pkg.sv]
// Scoreboard that predicts and checks floor square roots of accepted requests.
package isr64_root_scoreboard_pkg;

    import isr64_pkg::*;

    class root_scoreboard;

        int                  radicand_width;
        logic [ROOT_W-1:0]   expected_roots[$];
        int                  requests_noted;
        int                  roots_checked;
        int                  error_count;

        function new(int width);
            radicand_width = width;
            requests_noted = 0;
            roots_checked  = 0;
            error_count    = 0;
        endfunction

        // Restoring digit-by-digit root: two radicand bits in, one root bit out per step.
        function logic [ROOT_W-1:0] floor_sqrt(logic [RAD_W-1:0] value);
            logic [RAD_W-1:0] digits;
            logic [RAD_W+1:0] rem;
            logic [RAD_W+1:0] acc;
            logic [RAD_W+1:0] trial;
            int               steps;
            digits = value & ({RAD_W{1'b1}} >> (RAD_W - radicand_width));
            rem    = '0;
            acc    = '0;
            steps  = (radicand_width + 1) / 2;
            for (int i = steps; i > 0; i--)
            begin
                rem   = (rem << 2) | ((digits >> (2 * (i - 1))) & 64'd3);
                trial = (acc << 2) | 1;
                acc   = acc << 1;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    acc = acc | 1;
                end
            end
            return acc[ROOT_W-1:0];
        endfunction

        function void note_request(logic [RAD_W-1:0] value);
            expected_roots.push_back(floor_sqrt(value));
            requests_noted++;
        endfunction

        function void check_root(logic [ROOT_W-1:0] actual);
            logic [ROOT_W-1:0] expected;
            if (expected_roots.size() == 0)
            begin
                $error("root: result with no request pending, actual %0d", actual);
                error_count++;
                return;
            end
            expected = expected_roots.pop_front();
            roots_checked++;
            if (actual !== expected)
            begin
                $error("root mismatch: expected %0d, actual %0d", expected, actual);
                error_count++;
            end
        endfunction

    endclass

endpackage

[verif/tb_top.sv]
// Testbench top for the integer square root unit: stimulus, monitor and end of run.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import isr64_pkg::*;
    import isr64_root_scoreboard_pkg::*;

    localparam int RADICAND_WIDTH = DEF_RADICAND_WIDTH;
    localparam int LATENCY        = (RADICAND_WIDTH + 1) / 2;
    localparam int RANDOM_ITEMS   = 1400;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [RAD_W-1:0]   radicand;
    logic               done;
    logic [ROOT_W-1:0]  root;

    root_scoreboard     sb;
    int                 sender_idle_pct;
    int                 directed_count;

    integer_square_root_64_unit #(
        .RADICAND_WIDTH (RADICAND_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .radicand (radicand),
        .done     (done),
        .root     (root)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_root(root);
    end

    // Hold the request until it is taken; idle at random before raising start.
    task automatic send_request(logic [RAD_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        radicand <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(value);
    endtask

    function automatic logic [RAD_W-1:0] pick_radicand();
        logic [RAD_W-1:0] r;
        logic [RAD_W-1:0] value;
        case ($urandom_range(0, 5))
            0: value = {$urandom, $urandom};
            1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
            2:
            begin
                // Land on or next to a perfect square.
                r     = {32'd0, $urandom};
                value = r * r + $urandom_range(0, 4) - 2;
            end
            3: value = {RAD_W{1'b1}} - {32'd0, $urandom} - {$urandom_range(0, 3), 32'd0};
            4: value = {32'd0, $urandom_range(0, 1000)};
            default: value = {$urandom, $urandom};
        endcase
        return value;
    endfunction

    task automatic run_directed();
        logic [RAD_W-1:0] corner[$];
        corner = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
            64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
            64'hFFFF_FFFD_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
            64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h0000_0000_0001_0000, 64'h0000_0000_0000_FFFF
        };
        foreach (corner[i])
            send_request(corner[i]);
        directed_count = corner.size();
    endtask

    initial
    begin
        int drain_cycles;
        sb              = new(RADICAND_WIDTH);
        start           = 1'b0;
        radicand        = '0;
        rst_n           = 1'b0;
        sender_idle_pct = 33;
        directed_count  = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 70 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_request(pick_radicand());
        end
        @(negedge clk);
        start <= 1'b0;

        // Drain the pipeline, then wait on to catch stray strobes.
        drain_cycles = 0;
        while (sb.expected_roots.size() != 0 && drain_cycles < 10 * LATENCY + 100)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (sb.expected_roots.size() != 0)
        begin
            $error("root: %0d expected results never arrived", sb.expected_roots.size());
            sb.error_count++;
        end

        $display("Covered %0d root requests (%0d directed corners) under 33%%, 70%% and no idling;",
                 sb.requests_noted, directed_count);
        $display("%0d roots compared, %0d errors", sb.roots_checked, sb.error_count);
        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
sv/isr64_pkg.sv
sv/isr64_stage.sv
sv/integer_square_root_64_unit.sv
verif/isr64_root_scoreboard_pkg.sv
verif/tb_top.sv
